[hw/rtl/ects_pkg.sv]
// ----------------------------------------------------------------------------
// ects_pkg
// Shared constants, types and small table functions for the epoch seconds
// to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ects_pkg;

  // field widths
  localparam int unsigned SecsW   = 32;
  localparam int unsigned DayNumW = 16;
  localparam int unsigned YearW   = 12;

  // time constants
  localparam logic [SecsW-1:0] SecsPerDay      = 32'd86400;
  localparam logic [SecsW-1:0] SecsPerHour     = 32'd3600;
  localparam logic [SecsW-1:0] SecsPerMin      = 32'd60;
  localparam logic [SecsW-1:0] LastValidSecond = 32'd4102444799;

  // floor of two to the 32 over each divisor; for any 32-bit dividend the
  // quotient estimate is exact or low by one
  localparam logic [SecsW-1:0] RecipDay  = 32'((64'd1 << SecsW) / 64'(SecsPerDay));
  localparam logic [SecsW-1:0] RecipHour = 32'((64'd1 << SecsW) / 64'(SecsPerHour));
  localparam logic [SecsW-1:0] RecipMin  = 32'((64'd1 << SecsW) / 64'(SecsPerMin));

  // calendar constants
  localparam logic [YearW-1:0]   BaseYear        = 12'd1970;
  localparam logic [YearW-1:0]   CenturyBase     = 12'd1900;
  localparam logic [YearW-1:0]   NoLeapCentury   = 12'd2100;
  localparam logic [DayNumW-1:0] DaysPerYear     = 16'd365;
  localparam logic [DayNumW-1:0] DaysPerLeapYear = 16'd366;
  localparam logic [3:0]         MonthsPerYear   = 4'd12;
  localparam logic [3:0]         MarchIdx        = 4'd2;

  // divisor select of the shared divider
  typedef enum logic [1:0] {
    DIV_DAY  = 2'd0,
    DIV_HOUR = 2'd1,
    DIV_MIN  = 2'd2
  } div_sel_e;

  // sub-steps of one division: estimate, back-multiply, correct
  typedef enum logic [1:0] {
    DIV_FIX = 2'd0,
    DIV_SUB = 2'd1,
    DIV_EST = 2'd2
  } div_step_e;

  // controller to datapath
  typedef struct packed {
    logic             load_in;
    logic             div_en;
    div_sel_e         div_sel;
    div_step_e        div_step;
    logic             walk_start;
    logic             year_step;
    logic             month_step;
    logic             cache_wr;
    logic             load_out;
  } ects_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cache_hit;
    logic year_done;
    logic month_done;
  } ects_status_t;

  // one result beat
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        out_of_range;
  } ects_result_t;

  // days in month, index from 0 for January
  function automatic logic [4:0] month_length(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    unique case (idx)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // weekday offset of each month, index from 0 for January
  function automatic logic [2:0] month_offset(input logic [3:0] idx);
    logic [2:0] ofs;
    unique case (idx)
      4'd0, 4'd9:        ofs = 3'd0;
      4'd1, 4'd2, 4'd10: ofs = 3'd3;
      4'd3, 4'd6:        ofs = 3'd6;
      4'd4:              ofs = 3'd1;
      4'd5:              ofs = 3'd4;
      4'd7:              ofs = 3'd2;
      4'd8, 4'd11:       ofs = 3'd5;
      default:           ofs = 3'd0;
    endcase
    return ofs;
  endfunction

  // remainder by seven: eight is one mod seven, so fold the octal digits
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = {3'b000, x[7:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
    s2 = {2'b00, s1[4:3]} + {1'b0, s1[2:0]};
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ects_if.sv]
// ----------------------------------------------------------------------------
// ects_if
// Valid/ready channels of the converter: seconds count in, calendar out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ects_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] seconds_count;

  modport source (output valid, output seconds_count, input ready);
  modport sink   (input valid, input seconds_count, output ready);
endinterface

interface ects_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;
  logic        out_of_range;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output weekday,
                  output out_of_range, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input weekday,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

[hw/rtl/epoch_seconds_to_calendar.sv]
// Timing: a cached day skips the year and month walk; after a day change
//   the walk runs one year or month per cycle, the year walk up to 129 steps.
// Throughput: one item at a time; the next beat is taken the cycle after the
//   result enters the output register, which waits out any output stall.
// Reset (rst_ni low, asynchronous): handshakes idle, date cache invalid.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a seconds count since 1970-01-01 00:00:00 into calendar date,
// time of day and weekday, saturating past the end of 2099.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar import ects_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ects_in_if.sink   in_i,
  ects_out_if.source out_o
);

  ects_cmd_t    cmd;
  ects_status_t status;
  ects_result_t result;

  // sequencer
  ects_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  ects_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seconds_count_i (in_i.seconds_count),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_o        (result)
  );

  // result beat onto the output channel
  assign out_o.year         = result.year;
  assign out_o.month        = result.month;
  assign out_o.day_of_month = result.day_of_month;
  assign out_o.hour         = result.hour;
  assign out_o.minute       = result.minute;
  assign out_o.second       = result.second;
  assign out_o.weekday      = result.weekday;
  assign out_o.out_of_range = result.out_of_range;

endmodule

`default_nettype wire

[hw/rtl/ects_datapath.sv]
// ----------------------------------------------------------------------------
// ects_datapath
// Reciprocal divider for day number and time of day, year and month
// walk, last-day cache, weekday formula and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ects_datapath import ects_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [31:0]  seconds_count_i,
  input  wire ects_cmd_t    cmd_i,
  output ects_status_t      status_o,
  output ects_result_t      result_o
);

  logic [SecsW-1:0]   rem_q, rem_d;
  logic               over_q;
  logic [DayNumW-1:0] quot_q;
  logic [DayNumW-1:0] day_num_q;
  logic [4:0]         hour_q;
  logic [5:0]         min_q;

  logic [DayNumW-1:0] walk_days_q;
  logic [YearW-1:0]   walk_year_q;
  logic [3:0]         walk_month_q;

  logic               cache_valid_q;
  logic [DayNumW-1:0] cached_day_number_q;
  logic [YearW-1:0]   cached_year_q;
  logic [3:0]         cached_month_q;
  logic [4:0]         cached_day_q;

  ects_result_t       result_q, result_d;

  logic [SecsW-1:0]   divisor;
  logic [SecsW-1:0]   recip;
  logic [2*SecsW-1:0] prod;
  logic [SecsW-1:0]   back;
  logic [DayNumW-1:0] quot_fix;
  logic               fits;
  logic               leap;
  logic [4:0]         cur_len;
  logic [7:0]         yl;
  logic [7:0]         yl_sum;
  logic [5:0]         wd_sum;
  logic               wd_adj;

  // divisor and reciprocal of the current phase; the estimate is at most
  // one low, so one compare and subtract finishes the division
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_DAY: begin
        divisor = SecsPerDay;
        recip   = RecipDay;
      end
      DIV_HOUR: begin
        divisor = SecsPerHour;
        recip   = RecipHour;
      end
      default: begin
        divisor = SecsPerMin;
        recip   = RecipMin;
      end
    endcase
    prod     = {{SecsW{1'b0}}, rem_q} * {{SecsW{1'b0}}, recip};
    back     = {{(SecsW-DayNumW){1'b0}}, quot_q} * divisor;
    fits     = (rem_q >= divisor);
    rem_d    = fits ? (rem_q - divisor) : rem_q;
    quot_fix = quot_q + {{(DayNumW-1){1'b0}}, fits};
  end

  // input capture with saturation past the end of 2099, then division steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      rem_q  <= (seconds_count_i > LastValidSecond) ? LastValidSecond : seconds_count_i;
      over_q <= (seconds_count_i > LastValidSecond);
    end else if (cmd_i.div_en) begin
      unique case (cmd_i.div_step)
        DIV_EST: quot_q <= prod[SecsW +: DayNumW];
        DIV_SUB: rem_q  <= rem_q - back;
        default: begin
          rem_q <= rem_d;
          unique case (cmd_i.div_sel)
            DIV_DAY:  day_num_q <= quot_fix;
            DIV_HOUR: hour_q    <= quot_fix[4:0];
            default:  min_q     <= quot_fix[5:0];
          endcase
        end
      endcase
    end
  end

  // century years: 2000 (in reach, leap) and 2100 (not leap)
  assign leap    = (walk_year_q[1:0] == 2'b00) && (walk_year_q != NoLeapCentury);
  assign cur_len = month_length(walk_month_q, leap);

  assign status_o.cache_hit  = cache_valid_q && (cached_day_number_q == day_num_q);
  assign status_o.year_done  = leap ? (walk_days_q < DaysPerLeapYear)
                                    : (walk_days_q < DaysPerYear);
  assign status_o.month_done = (walk_month_q == MonthsPerYear) ||
                               (walk_days_q < {11'd0, cur_len});

  // year then month walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      walk_days_q  <= day_num_q;
      walk_year_q  <= BaseYear;
      walk_month_q <= 4'd0;
    end else if (cmd_i.year_step) begin
      walk_days_q <= walk_days_q - (leap ? DaysPerLeapYear : DaysPerYear);
      walk_year_q <= walk_year_q + 12'd1;
    end else if (cmd_i.month_step) begin
      walk_days_q  <= walk_days_q - {11'd0, cur_len};
      walk_month_q <= walk_month_q + 4'd1;
    end
  end

  // last day cache
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_valid_q       <= 1'b0;
      cached_day_number_q <= '0;
      cached_year_q       <= BaseYear;
      cached_month_q      <= 4'd1;
      cached_day_q        <= 5'd1;
    end else if (cmd_i.cache_wr) begin
      cache_valid_q       <= 1'b1;
      cached_day_number_q <= day_num_q;
      cached_year_q       <= walk_year_q;
      cached_month_q      <= walk_month_q + 4'd1;
      cached_day_q        <= walk_days_q[4:0] + 5'd1;
    end
  end

  // weekday: years since 1900 plus leap count, day and month offset
  always_comb begin
    yl     = 8'(cached_year_q - CenturyBase);
    yl_sum = yl + {2'b00, yl[7:2]};
    wd_adj = (yl[1:0] == 2'b00) && (cached_month_q <= MarchIdx);
    wd_sum = {3'b000, mod7(yl_sum)} + {1'b0, cached_day_q}
           + {3'b000, month_offset(cached_month_q - 4'd1)} - {5'd0, wd_adj};

    result_d.year         = cached_year_q;
    result_d.month        = cached_month_q;
    result_d.day_of_month = cached_day_q;
    result_d.hour         = hour_q;
    result_d.minute       = min_q;
    result_d.second       = rem_q[5:0];
    result_d.weekday      = mod7({2'b00, wd_sum});
    result_d.out_of_range = over_q;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

[hw/rtl/ects_ctrl.sv]
// ----------------------------------------------------------------------------
// ects_ctrl
// Sequencer: divider phases, cache check, year and month walk, result
// hand-off and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ects_ctrl import ects_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire ects_status_t  status_i,
  output ects_cmd_t          cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DDAY  = 8'b0000_0010,
    S_DHOUR = 8'b0000_0100,
    S_DMIN  = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_YEAR  = 8'b0010_0000,
    S_MONTH = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  div_step_e        step_q, step_d, step_next;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.div_sel  = DIV_DAY;
    cmd_o.div_step = step_q;

    // division sub-step order: estimate, back-multiply, correct
    unique case (step_q)
      DIV_EST: step_next = DIV_SUB;
      DIV_SUB: step_next = DIV_FIX;
      default: step_next = DIV_EST;
    endcase

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          step_d  = DIV_EST;
          state_d = S_DDAY;
        end
      end
      S_DDAY: begin
        cmd_o.div_en = 1'b1;
        step_d = step_next;
        if (step_q == DIV_FIX) begin
          state_d = S_DHOUR;
        end
      end
      S_DHOUR: begin
        cmd_o.div_en  = 1'b1;
        cmd_o.div_sel = DIV_HOUR;
        step_d = step_next;
        if (step_q == DIV_FIX) begin
          state_d = S_DMIN;
        end
      end
      S_DMIN: begin
        cmd_o.div_en  = 1'b1;
        cmd_o.div_sel = DIV_MIN;
        step_d = step_next;
        if (step_q == DIV_FIX) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.cache_hit) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d = S_YEAR;
        end
      end
      S_YEAR: begin
        if (status_i.year_done) begin
          state_d = S_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (status_i.month_done) begin
          cmd_o.cache_wr = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= DIV_EST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ects_checker.sv]
// ----------------------------------------------------------------------------
// ects_port_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ects_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [11:0] year_i,
  input wire logic [3:0]  month_i,
  input wire logic [4:0]  day_of_month_i,
  input wire logic [4:0]  hour_i,
  input wire logic [5:0]  minute_i,
  input wire logic [5:0]  second_i,
  input wire logic [2:0]  weekday_i,
  input wire logic        out_of_range_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(year_i) && $stable(month_i)
      && $stable(day_of_month_i) && $stable(hour_i) && $stable(minute_i)
      && $stable(second_i) && $stable(weekday_i) && $stable(out_of_range_i))
    else $error("result changed while stalled");

  // one item at a time: no new beat right after one is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // each field stays in its calendar range; day of month only from below
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> year_i >= 12'd1970 && year_i <= 12'd2099
      && month_i >= 4'd1 && month_i <= 4'd12
      && day_of_month_i >= 5'd1 && hour_i <= 5'd23
      && minute_i <= 6'd59 && second_i <= 6'd59 && weekday_i <= 3'd6)
    else $error("field out of range");

  // saturated result is the last second of 2099, a Thursday
  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_of_range_i |-> year_i == 12'd2099 && month_i == 4'd12
      && day_of_month_i == 5'd31 && hour_i == 5'd23 && minute_i == 6'd59
      && second_i == 6'd59 && weekday_i == 3'd4)
    else $error("saturated result wrong");

endmodule

bind epoch_seconds_to_calendar ects_port_checker u_ects_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .year_i         (out_o.year),
  .month_i        (out_o.month),
  .day_of_month_i (out_o.day_of_month),
  .hour_i         (out_o.hour),
  .minute_i       (out_o.minute),
  .second_i       (out_o.second),
  .weekday_i      (out_o.weekday),
  .out_of_range_i (out_o.out_of_range)
);

`default_nettype wire

[bench/ects_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ects_checker
// Watches the seconds and calendar channels of the converter. Each accepted
// seconds beat is turned into an expected calendar beat by an independent
// date model with its own day cache. Each accepted calendar beat is compared
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------

module ects_checker import ects_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ects_in_if          sec_i,
  ects_out_if         cal_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  localparam int unsigned DaysInMonth[12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned WeekdayShift[12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

  // date cache of the model, keyed by day number
  logic [DayNumW-1:0] cache_day_num;
  logic               cache_ok;
  logic [YearW-1:0]   cache_year;
  logic [3:0]         cache_month;
  logic [4:0]         cache_day;

  ects_result_t expected_dates[$];

  function automatic bit has_feb29(input int unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  // weekday by the month-offset formula, good for 1901 to 2099
  function automatic logic [2:0] weekday_from_date(input int unsigned y, input int unsigned mon,
                                                   input int unsigned d);
    int unsigned yl;
    int unsigned t;
    yl = y % 100;
    if (y / 100 > 19) yl += 100;
    t = (yl + yl / 4) % 7 + d + WeekdayShift[mon - 1];
    if (yl % 4 == 0 && mon < 3) t--;
    return 3'(t % 7);
  endfunction

  // full calendar beat for one seconds count, updates the date cache
  function automatic ects_result_t predict_calendar(input logic [SecsW-1:0] secs_in);
    ects_result_t r;
    logic [SecsW-1:0] secs;
    logic             over;
    int unsigned      days;
    int unsigned      tod;
    int unsigned      rem;
    int unsigned      y;
    int unsigned      m;
    int unsigned      len;
    secs = secs_in;
    over = 1'b0;
    // saturate past the last second of 2099
    if (secs > LastValidSecond) begin
      secs = LastValidSecond;
      over = 1'b1;
    end
    days = secs / SecsPerDay;
    // walk years then months only when the day changes
    if (!cache_ok || cache_day_num != days[DayNumW-1:0]) begin
      cache_day_num = days[DayNumW-1:0];
      cache_ok      = 1'b1;
      rem = days;
      y   = BaseYear;
      m   = 0;
      while (rem >= 365) begin
        if (has_feb29(y)) begin
          // last day of a leap year stays in that year
          if (rem >= 366) rem -= 366;
          else break;
        end else begin
          rem -= 365;
        end
        y++;
      end
      while (m < 12) begin
        len = DaysInMonth[m];
        if (m == 1 && has_feb29(y)) len = 29;
        if (rem >= len) rem -= len;
        else break;
        m++;
      end
      cache_year  = YearW'(y);
      cache_month = 4'(m + 1);
      cache_day   = 5'(rem + 1);
    end
    tod = secs % SecsPerDay;
    r.year         = cache_year;
    r.month        = cache_month;
    r.day_of_month = cache_day;
    r.hour         = 5'(tod / SecsPerHour);
    r.minute       = 6'((tod % SecsPerHour) / SecsPerMin);
    r.second       = 6'(tod % SecsPerMin);
    r.weekday      = weekday_from_date(cache_year, cache_month, cache_day);
    r.out_of_range = over;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count_o++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    ects_result_t want;
    if (!rst_ni) begin
      cache_day_num = '0;
      cache_ok      = 1'b0;
      cache_year    = BaseYear;
      cache_month   = 4'd1;
      cache_day     = 5'd1;
      expected_dates.delete();
      mismatch_count_o = 0;
    end else begin
      // seconds beat taken
      if (sec_i.valid && sec_i.ready) begin
        expected_dates.push_back(predict_calendar(sec_i.seconds_count));
      end
      // calendar beat delivered
      if (cal_i.valid && cal_i.ready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("calendar beat with nothing expected");
        end else begin
          want = expected_dates.pop_front();
          check_field("year", cal_i.year, want.year);
          check_field("month", cal_i.month, want.month);
          check_field("day_of_month", cal_i.day_of_month, want.day_of_month);
          check_field("hour", cal_i.hour, want.hour);
          check_field("minute", cal_i.minute, want.minute);
          check_field("second", cal_i.second, want.second);
          check_field("weekday", cal_i.weekday, want.weekday);
          check_field("out_of_range", cal_i.out_of_range, want.out_of_range);
        end
      end
    end
    pending_o = expected_dates.size();
  end

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

endmodule

[bench/epoch_seconds_to_calendar_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_test
// Drives seconds counts into the converter: directed dates first (epoch,
// day and year edges, leap days, the last day of a leap year, repeated days
// for the date cache, saturation past 2099), then random counts that mix
// same-day runs, day boundaries and out-of-range values. Both channels idle
// at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module epoch_seconds_to_calendar_test;
  import ects_pkg::*;

  localparam int unsigned RandomItems = 550;
  localparam int unsigned IdlePercent = 15;
  localparam int unsigned LastDayNum  = 47481;

  logic        clk_i;
  logic        rst_ni;
  logic        steady;
  int unsigned mismatch_count;
  int unsigned pending;
  logic [31:0] prev_secs;

  ects_in_if  sec_ch ();
  ects_out_if cal_ch ();

  epoch_seconds_to_calendar u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sec_ch),
    .out_o  (cal_ch)
  );

  ects_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sec_i            (sec_ch),
    .cal_i            (cal_ch),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // calendar side back-pressure
  always @(posedge clk_i) begin
    cal_ch.ready <= rst_ni && (steady || $urandom_range(99) >= IdlePercent);
  end

  // one seconds beat, with random idle cycles in front of it
  task automatic send_seconds(input logic [31:0] secs);
    if (!steady && $urandom_range(99) < IdlePercent) begin
      sec_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 50);
    end
    sec_ch.valid         <= 1'b1;
    sec_ch.seconds_count <= secs;
    do @(posedge clk_i); while (!sec_ch.ready);
    prev_secs = secs;
  endtask

  initial begin
    logic [31:0] secs;
    sec_ch.valid         = 1'b0;
    sec_ch.seconds_count = '0;
    cal_ch.ready         = 1'b0;
    steady               = 1'b0;
    prev_secs            = '0;
    rst_ni               = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: epoch, day edges and cache hits
    send_seconds(32'd0);
    send_seconds(32'd0);
    send_seconds(32'd1);
    send_seconds(32'd86399);
    send_seconds(32'd86400);
    // non-leap february end and march start
    send_seconds(32'd5097599);
    send_seconds(32'd5097600);
    // last day of a leap year, start and end
    send_seconds(32'd94608000);
    send_seconds(32'd94694399);
    send_seconds(32'd94694400);
    // century leap year 2000
    send_seconds(32'd946684799);
    send_seconds(32'd946684800);
    send_seconds(32'd951782400);
    send_seconds(32'd978220800);
    send_seconds(32'd978307199);
    // end of the range and saturation past 2099
    send_seconds(32'd4102358400);
    send_seconds(LastValidSecond);
    send_seconds(32'd4102444800);
    send_seconds(32'hFFFF_FFFF);
    send_seconds(LastValidSecond);
    send_seconds(32'h5555_5555);
    send_seconds(32'hAAAA_AAAA);
    send_seconds(32'd0);

    // random counts
    for (int i = 0; i < RandomItems; i++) begin
      steady = (i >= 200 && i < 300);
      case ($urandom_range(9))
        0, 1, 2, 3: secs = $urandom();
        // same day as the last one, mostly a cache hit
        4, 5, 6: secs = prev_secs + $urandom_range(3600);
        // first or last second of a random day
        7, 8: secs = $urandom_range(LastDayNum) * SecsPerDay +
                     ($urandom_range(1) ? 32'd86399 : 32'd0);
        default: secs = $urandom_range(32'hFFFF_FFFF, LastValidSecond - 32'd100);
      endcase
      send_seconds(secs);
    end
    steady = 1'b0;
    sec_ch.valid <= 1'b0;

    // let the checker log the last beat, drain, then let the block settle
    @(posedge clk_i);
    for (int n = 0; n < 5000 && pending != 0; n++) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (pending != 0) begin
      $display("%0d calendar beats never arrived", pending);
    end
    if (mismatch_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
